[rtl/core/rmsc_pkg.sv]
// shared types, constants and pixel mapping for the rgb matrix scan controller
package rmsc_pkg;

    localparam int ROW_W   = 4;
    localparam int ROWS    = 16;
    localparam int PLANE_W = 64;
    localparam int BIT_W   = 6;
    localparam int POS_W   = 7;
    localparam int ROWSEL_W = 3;
    localparam int COLOR_W = 6;

    // pin order of the six color data bits
    localparam int COLOR_RED_UP   = 0;
    localparam int COLOR_BLUE_UP  = 1;
    localparam int COLOR_GREEN_UP = 2;
    localparam int COLOR_RED_LO   = 3;
    localparam int COLOR_BLUE_LO  = 4;
    localparam int COLOR_GREEN_LO = 5;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_SCAN  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // scan sequencer view of one tick
    typedef struct packed {
        logic                shift;
        logic [ROW_W-1:0]    up_row;
        logic [ROW_W-1:0]    lo_row;
        logic [POS_W-1:0]    bit_pos;
        logic [ROWSEL_W-1:0] row_sel;
    } scan_ctrl_t;

    // logical row to store row: lower bands fold down
    function automatic logic [ROW_W-1:0] store_row(input logic [4:0] row);
        return {row[4], row[2:0]};
    endfunction

    // logical column to bit index inside a store row, msb first
    function automatic logic [BIT_W-1:0] store_bit(input logic [4:0] row,
                                                   input logic [4:0] col);
        logic [BIT_W-1:0] col_ext;
        logic [BIT_W-1:0] scol;
        col_ext = {1'b0, col};
        if (row[3])
        begin
            scol = col[4] ? col_ext + 6'd32 : col_ext + 6'd16;
        end
        else
        begin
            scol = col[4] ? col_ext + 6'd16 : col_ext;
        end
        return ~scol;
    endfunction

endpackage

[rtl/core/rmsc_store.sv]
// frame store: three color planes, row valid bits and a registered two-row read
module rmsc_store
    import rmsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic                clr_en,
    input  logic [ROW_W-1:0]    wr_row,
    input  logic [BIT_W-1:0]    wr_bit,
    input  logic                wr_red,
    input  logic                wr_green,
    input  logic                wr_blue,
    input  logic                rd_en,
    input  logic [ROW_W-1:0]    rd_up_row,
    input  logic [ROW_W-1:0]    rd_lo_row,
    input  logic [POS_W-1:0]    rd_pos,
    output logic [COLOR_W-1:0]  rd_color
);

    logic [PLANE_W-1:0] red_mem   [ROWS];
    logic [PLANE_W-1:0] green_mem [ROWS];
    logic [PLANE_W-1:0] blue_mem  [ROWS];

    logic [ROWS-1:0]    valid_reg;
    logic [COLOR_W-1:0] rd_color_reg;
    logic [COLOR_W-1:0] rd_color_next;
    logic [BIT_W-1:0]   rd_bit;
    logic               in_range;
    logic               up_ok;
    logic               lo_ok;

    // row valid bits: a cleared row reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr_en)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_row] <= 1'b1;
        end
    end

    // pixel write; a row that is not valid is zeroed around the new bit
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int b = 0; b < PLANE_W; b++)
            begin
                if (!valid_reg[wr_row] || (BIT_W'(b) == wr_bit))
                begin
                    red_mem[wr_row][b]   <= (BIT_W'(b) == wr_bit) && wr_red;
                    green_mem[wr_row][b] <= (BIT_W'(b) == wr_bit) && wr_green;
                    blue_mem[wr_row][b]  <= (BIT_W'(b) == wr_bit) && wr_blue;
                end
            end
        end
    end

    // read of one bit in the upper and the lower scan row
    assign rd_bit   = ~rd_pos[BIT_W-1:0];
    assign in_range = !rd_pos[POS_W-1];
    assign up_ok    = valid_reg[rd_up_row] && in_range;
    assign lo_ok    = valid_reg[rd_lo_row] && in_range;

    always_comb
    begin
        rd_color_next                 = '0;
        rd_color_next[COLOR_RED_UP]   = up_ok && red_mem[rd_up_row][rd_bit];
        rd_color_next[COLOR_BLUE_UP]  = up_ok && blue_mem[rd_up_row][rd_bit];
        rd_color_next[COLOR_GREEN_UP] = up_ok && green_mem[rd_up_row][rd_bit];
        rd_color_next[COLOR_RED_LO]   = lo_ok && red_mem[rd_lo_row][rd_bit];
        rd_color_next[COLOR_BLUE_LO]  = lo_ok && blue_mem[rd_lo_row][rd_bit];
        rd_color_next[COLOR_GREEN_LO] = lo_ok && green_mem[rd_lo_row][rd_bit];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_color_reg <= rd_color_next;
        end
    end

    assign rd_color = rd_color_reg;

endmodule

[rtl/core/rmsc_scan.sv]
// scan sequencer: shift position, scan line and latched row address
module rmsc_scan
    import rmsc_pkg::*;
#(
    parameter int SCAN_LINES   = 8,
    parameter int SHIFT_LENGTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    output scan_ctrl_t ctrl
);

    localparam int LINE_W = $clog2(SCAN_LINES);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(SCAN_LINES - 1);
    localparam logic [POS_W:0]    SHIFT_END = (POS_W + 1)'(SHIFT_LENGTH);
    localparam logic [ROW_W-1:0]  LO_OFFSET = ROW_W'(SCAN_LINES);

    logic [LINE_W-1:0]   scan_line_reg;
    logic [LINE_W-1:0]   scan_line_next;
    logic [POS_W-1:0]    shift_pos_reg;
    logic [POS_W-1:0]    shift_pos_next;
    logic [ROWSEL_W-1:0] held_row_reg;
    logic [ROWSEL_W-1:0] held_row_next;
    logic                in_shift;
    logic [ROW_W-1:0]    up_row;

    assign in_shift = {1'b0, shift_pos_reg} < SHIFT_END;
    assign up_row   = ROW_W'(scan_line_reg);

    // next scan state for a tick
    always_comb
    begin
        scan_line_next = scan_line_reg;
        shift_pos_next = shift_pos_reg;
        held_row_next  = held_row_reg;
        if (in_shift)
        begin
            shift_pos_next = shift_pos_reg + 1'b1;
        end
        else
        begin
            held_row_next  = up_row[ROWSEL_W-1:0];
            shift_pos_next = '0;
            scan_line_next = (scan_line_reg == LAST_LINE) ? '0 : scan_line_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_line_reg <= '0;
            shift_pos_reg <= '0;
            held_row_reg  <= '0;
        end
        else if (tick)
        begin
            scan_line_reg <= scan_line_next;
            shift_pos_reg <= shift_pos_next;
            held_row_reg  <= held_row_next;
        end
    end

    // what this tick reads and drives
    assign ctrl.shift   = in_shift;
    assign ctrl.up_row  = up_row;
    assign ctrl.lo_row  = up_row + LO_OFFSET;
    assign ctrl.bit_pos = shift_pos_reg;
    assign ctrl.row_sel = held_row_next;

endmodule

[rtl/core/rgb_matrix_scan_controller_top.sv]
// top level of the rgb matrix scan controller
//
// Frame store and scan-out for a 32x32 one-bit RGB panel at 1/8 scan.
// Input channel (in_valid / in_stall): func selects a pixel write, a clear
// of the whole store, one scan tick or no action; pixel_row, pixel_column
// and the three color bits go with a write. Writes and clears take effect at
// the accepting edge and give no output transaction.
// Output channel (out_valid / out_stall): one transaction per scan tick with
// the six color data pins, shift_pulse, latch_pulse, blank_pulse and
// row_select for the panel. SHIFT_LENGTH shift ticks are followed by one
// latch tick per scan line.
// Two register stages: the store read register, then the output register. A
// tick is registered into the read stage at the accepting edge and then into
// the output register. Throughput: one item per cycle while out_stall is low.
// Reset: row valid bits clear at once, so the store reads as zero with no
// clearing pass; the scan starts at line 0, position 0.
// While the receiver stalls, the output holds; once the read stage is also
// full, in_stall rises until the output moves.
module rgb_matrix_scan_controller_top
    import rmsc_pkg::*;
#(
    parameter int SCAN_LINES   = 8,
    parameter int SHIFT_LENGTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [4:0] pixel_row,
    input  logic [4:0] pixel_column,
    input  logic       red_on,
    input  logic       green_on,
    input  logic       blue_on,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       red_upper,
    output logic       blue_upper,
    output logic       green_upper,
    output logic       red_lower,
    output logic       blue_lower,
    output logic       green_lower,
    output logic       shift_pulse,
    output logic       latch_pulse,
    output logic       blank_pulse,
    output logic [2:0] row_select
);

    func_t               func_code;
    logic                in_accept;
    logic                scan_tick;
    logic                advance;
    scan_ctrl_t          scan_ctrl;
    logic [COLOR_W-1:0]  rd_color;

    logic                s1_valid_reg;
    logic                s1_shift_reg;
    logic [ROWSEL_W-1:0] s1_row_reg;

    logic                out_valid_reg;
    logic                out_shift_reg;
    logic [COLOR_W-1:0]  out_color_reg;
    logic [COLOR_W-1:0]  out_color_next;
    logic [ROWSEL_W-1:0] out_row_reg;
    logic [COLOR_W-1:0]  held_color_reg;

    // input handshake
    assign func_code = func_t'(func);
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign scan_tick = in_accept && (func_code == FUNC_SCAN);

    rmsc_scan #(
        .SCAN_LINES   (SCAN_LINES),
        .SHIFT_LENGTH (SHIFT_LENGTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (scan_tick),
        .ctrl  (scan_ctrl)
    );

    rmsc_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_accept && (func_code == FUNC_WRITE)),
        .clr_en    (in_accept && (func_code == FUNC_CLEAR)),
        .wr_row    (store_row(pixel_row)),
        .wr_bit    (store_bit(pixel_row, pixel_column)),
        .wr_red    (red_on),
        .wr_green  (green_on),
        .wr_blue   (blue_on),
        .rd_en     (scan_tick),
        .rd_up_row (scan_ctrl.up_row),
        .rd_lo_row (scan_ctrl.lo_row),
        .rd_pos    (scan_ctrl.bit_pos),
        .rd_color  (rd_color)
    );

    // read stage: tick kind and row address alongside the store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (scan_tick)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_tick)
        begin
            s1_shift_reg <= scan_ctrl.shift;
            s1_row_reg   <= scan_ctrl.row_sel;
        end
    end

    // latch ticks repeat the last shifted color word
    assign out_color_next = s1_shift_reg ? rd_color : held_color_reg;

    // output register and held color word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            held_color_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                held_color_reg <= out_color_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_shift_reg <= s1_shift_reg;
            out_color_reg <= out_color_next;
            out_row_reg   <= s1_row_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_upper   = out_color_reg[COLOR_RED_UP];
    assign blue_upper  = out_color_reg[COLOR_BLUE_UP];
    assign green_upper = out_color_reg[COLOR_GREEN_UP];
    assign red_lower   = out_color_reg[COLOR_RED_LO];
    assign blue_lower  = out_color_reg[COLOR_BLUE_LO];
    assign green_lower = out_color_reg[COLOR_GREEN_LO];
    assign shift_pulse = out_shift_reg;
    assign latch_pulse = !out_shift_reg;
    assign blank_pulse = !out_shift_reg;
    assign row_select  = out_row_reg;

endmodule

[rtl/core/rmsc_checker.sv]
// port-level checks for the rgb matrix scan controller, bound to the top level
module rmsc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       shift_pulse,
    input logic       latch_pulse,
    input logic       blank_pulse,
    input logic [2:0] row_select
);

    // blanking goes with the latch tick
    a_blank_with_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (latch_pulse == blank_pulse))
        else $error("blank_pulse differs from latch_pulse");

    // every transaction is either a shift tick or a latch tick
    a_shift_or_latch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shift_pulse != latch_pulse))
        else $error("shift_pulse and latch_pulse not exclusive");

    // input only stalls when a result is waiting on a stalled receiver
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |-> (out_valid && out_stall))
        else $error("input stalled with the output free");

    // stalled output transaction keeps its row select and shift pulse
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(row_select)
            && $stable(shift_pulse)))
        else $error("stalled output transaction changed");

endmodule

bind rgb_matrix_scan_controller_top rmsc_checker u_rmsc_checker (.*);

[tb/sv/tb_rgb_matrix_scan_controller_top.sv]
// testbench for the rgb matrix scan controller: directed table, random traffic, scoreboard
module tb_rgb_matrix_scan_controller_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rmsc_pkg::*;

    localparam int SCAN_LINES    = 8;
    localparam int SHIFT_LENGTH  = 64;
    localparam int DIR_LEN       = 22;
    localparam int RANDOM_ITEMS  = 1430;
    localparam int QUIET_TAIL    = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 8;

    // one panel pin word as seen on the output channel
    typedef struct packed {
        logic       red_up;
        logic       blue_up;
        logic       green_up;
        logic       red_lo;
        logic       blue_lo;
        logic       green_lo;
        logic       shift;
        logic       latch;
        logic       blank;
        logic [2:0] row_sel;
    } pin_word_t;

    // one input transaction, with an optional hand-typed expectation
    typedef struct packed {
        func_t      fn;
        logic [4:0] row;
        logic [4:0] col;
        logic       red;
        logic       green;
        logic       blue;
        logic       typed;
        pin_word_t  want;
    } pixel_cmd_t;

    localparam pin_word_t NO_PIN      = '0;
    // shift tick over an empty store before any latch
    localparam pin_word_t FIRST_SHIFT = {6'b000000, 1'b1, 1'b0, 1'b0, 3'd0};

    // directed table: corners, every band fold, ignored command, clear
    pixel_cmd_t dir_tab [DIR_LEN] = '{
        {FUNC_SCAN,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b1, FIRST_SHIFT},
        {FUNC_WRITE, 5'd0,  5'd0,  1'b1, 1'b1, 1'b1, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd0,  5'd1,  1'b1, 1'b1, 1'b1, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd16, 5'd1,  1'b1, 1'b0, 1'b1, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd8,  5'd2,  1'b0, 1'b1, 1'b0, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd24, 5'd3,  1'b1, 1'b1, 1'b0, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd15, 5'd31, 1'b1, 1'b0, 1'b1, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd23, 5'd16, 1'b0, 1'b1, 1'b1, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd7,  5'd15, 1'b1, 1'b1, 1'b1, 1'b0, NO_PIN},
        {FUNC_NONE,  5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, NO_PIN},
        {FUNC_SCAN,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_PIN},
        {FUNC_SCAN,  5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, NO_PIN},
        {FUNC_SCAN,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_PIN},
        {FUNC_WRITE, 5'd0,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0, NO_PIN},
        {FUNC_SCAN,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_PIN},
        {FUNC_CLEAR, 5'd17, 5'd9,  1'b1, 1'b0, 1'b1, 1'b0, NO_PIN},
        {FUNC_SCAN,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b1, FIRST_SHIFT},
        {FUNC_WRITE, 5'd31, 5'd0,  1'b1, 1'b1, 1'b1, 1'b0, NO_PIN},
        {FUNC_NONE,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_PIN},
        {FUNC_SCAN,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_PIN},
        {FUNC_SCAN,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0, NO_PIN}
    };

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_stall = 1'b0;
    pixel_cmd_t cur_cmd   = '0;
    logic       in_stall;
    logic       out_valid;
    logic       red_upper, blue_upper, green_upper;
    logic       red_lower, blue_lower, green_lower;
    logic       shift_pulse, latch_pulse, blank_pulse;
    logic [2:0] row_select;

    bit         idle_on      = 1'b1;
    bit         hold_request = 1'b0;
    int         faults       = 0;
    int         out_count    = 0;
    pin_word_t  pin_q [$];

    // predicted frame store and scan state
    logic [63:0] red_store   [16];
    logic [63:0] green_store [16];
    logic [63:0] blue_store  [16];
    logic [2:0]  line_q   = '0;
    logic [6:0]  pos_q    = '0;
    logic [2:0]  rowsel_q = '0;
    logic [5:0]  color_q  = '0;

    rgb_matrix_scan_controller_top #(
        .SCAN_LINES   (SCAN_LINES),
        .SHIFT_LENGTH (SHIFT_LENGTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (cur_cmd.fn),
        .pixel_row    (cur_cmd.row),
        .pixel_column (cur_cmd.col),
        .red_on       (cur_cmd.red),
        .green_on     (cur_cmd.green),
        .blue_on      (cur_cmd.blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_upper    (red_upper),
        .blue_upper   (blue_upper),
        .green_upper  (green_upper),
        .red_lower    (red_lower),
        .blue_lower   (blue_lower),
        .green_lower  (green_lower),
        .shift_pulse  (shift_pulse),
        .latch_pulse  (latch_pulse),
        .blank_pulse  (blank_pulse),
        .row_select   (row_select)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic clear_store();
        for (int r = 0; r < 16; r++)
        begin
            red_store[r]   = '0;
            green_store[r] = '0;
            blue_store[r]  = '0;
        end
    endtask

    // advance the predicted panel by one transaction, return the pin word of a scan tick
    task automatic panel_step(input pixel_cmd_t cmd, output bit produced,
                              output pin_word_t word);
        logic [3:0] srow;
        logic [5:0] scol;
        logic [5:0] idx;
        logic [3:0] up;
        logic [3:0] lo;
        produced = 1'b0;
        word     = NO_PIN;
        case (cmd.fn)
            FUNC_WRITE:
            begin
                // lower bands of each half fold onto the store rows
                if (cmd.row < 8)
                    srow = cmd.row[3:0];
                else if (cmd.row < 24)
                    srow = 4'(cmd.row - 8);
                else
                    srow = 4'(cmd.row - 16);
                scol = (cmd.col < 16) ? {1'b0, cmd.col} : {1'b0, cmd.col} + 6'd16;
                if (cmd.row[3])
                    scol = scol + 6'd16;
                idx = 6'd63 - scol;
                red_store[srow][idx]   = cmd.red;
                green_store[srow][idx] = cmd.green;
                blue_store[srow][idx]  = cmd.blue;
            end
            FUNC_CLEAR:
            begin
                clear_store();
            end
            FUNC_SCAN:
            begin
                produced = 1'b1;
                if (pos_q < SHIFT_LENGTH)
                begin
                    // shift tick: msb first from upper and lower store rows
                    up  = {1'b0, line_q};
                    lo  = up + 4'(SCAN_LINES);
                    idx = 6'(63 - pos_q);
                    color_q = {green_store[lo][idx], blue_store[lo][idx], red_store[lo][idx],
                               green_store[up][idx], blue_store[up][idx], red_store[up][idx]};
                    pos_q      = pos_q + 7'd1;
                    word.shift = 1'b1;
                end
                else
                begin
                    // latch tick: select the row just shifted, move to the next line
                    rowsel_q   = line_q;
                    word.latch = 1'b1;
                    word.blank = 1'b1;
                    line_q     = 3'((line_q + 1) % SCAN_LINES);
                    pos_q      = '0;
                end
                {word.green_lo, word.blue_lo, word.red_lo,
                 word.green_up, word.blue_up, word.red_up} = color_q;
                word.row_sel = rowsel_q;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic string pin_text(input pin_word_t w);
        return $sformatf("up rbg %b%b%b lo rbg %b%b%b shift %b latch %b blank %b row %0d",
                         w.red_up, w.blue_up, w.green_up, w.red_lo, w.blue_lo, w.green_lo,
                         w.shift, w.latch, w.blank, w.row_sel);
    endfunction

    function automatic pixel_cmd_t random_cmd();
        pixel_cmd_t c;
        int         pick;
        c    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            c.fn = FUNC_SCAN;
        else if (pick < 96)
            c.fn = FUNC_WRITE;
        else if (pick < 97)
            c.fn = FUNC_CLEAR;
        else
            c.fn = FUNC_NONE;
        c.row   = 5'($urandom_range(0, 31));
        c.col   = 5'($urandom_range(0, 31));
        c.red   = 1'($urandom_range(0, 1));
        c.green = 1'($urandom_range(0, 1));
        c.blue  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // scoreboard: predict on input transactions, check output transactions
    always @(posedge clk)
    begin : scoreboard
        bit        produced;
        pin_word_t word;
        pin_word_t seen;
        pin_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                panel_step(cur_cmd, produced, word);
                if (produced)
                    pin_q.push_back(cur_cmd.typed ? cur_cmd.want : word);
            end
            if (out_valid && !out_stall)
            begin
                seen = {red_upper, blue_upper, green_upper, red_lower, blue_lower,
                        green_lower, shift_pulse, latch_pulse, blank_pulse, row_select};
                if (pin_q.size() == 0)
                begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("output %0d with nothing expected: %s", out_count,
                                 pin_text(seen));
                end
                else
                begin
                    want = pin_q.pop_front();
                    if (seen !== want)
                    begin
                        faults++;
                        if (faults <= MAX_REPORTS)
                            $display("output %0d mismatch: expected %s, got %s", out_count,
                                     pin_text(want), pin_text(seen));
                    end
                end
                out_count++;
            end
        end
    end

    // receiver: random stall bursts plus one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall    <= 1'b0;
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // sender: directed table, then random traffic, then drain and verdict
    initial
    begin
        int         total;
        pixel_cmd_t cmd;
        total = DIR_LEN + RANDOM_ITEMS;
        clear_store();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int n = 0; n < total; n++)
        begin
            if (n >= total - QUIET_TAIL)
                idle_on = 1'b0;
            else if (n % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n == DIR_LEN + 300)
                hold_request = 1'b1;
            // pause until the output side has caught up completely
            if (n == DIR_LEN + 700)
            begin
                in_valid <= 1'b0;
                do @(negedge clk); while (pin_q.size() != 0);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            cmd = (n < DIR_LEN) ? dir_tab[n] : random_cmd();
            cur_cmd  <= cmd;
            in_valid <= 1'b1;
            do @(posedge clk); while (in_stall);
            @(negedge clk);
        end
        in_valid <= 1'b0;
        while (pin_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (faults == 0 && pin_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[rgb_matrix_scan_controller_top.f]
rtl/core/rmsc_pkg.sv
rtl/core/rmsc_store.sv
rtl/core/rmsc_scan.sv
rtl/core/rgb_matrix_scan_controller_top.sv
rtl/core/rmsc_checker.sv
tb/sv/tb_rgb_matrix_scan_controller_top.sv
